### src/rtp_pkg.sv
`timescale 1ns / 1ps

package rtp_pkg;

  // Accumulator width; values wrap modulo 2**VALUE_BITS.
  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int CHAR_BITS  = 8;
  localparam int MODE_BITS  = 2;
  localparam int DIGIT_BITS = 4;

  localparam logic [MODE_BITS-1:0] MODE_BIN = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_OCT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DEC = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_HEX = 2'd3;
  localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_DEC;

  localparam logic [CHAR_BITS-1:0] CHAR_MASK    = 8'o377;
  localparam logic [CHAR_BITS-1:0] CH_MINUS     = 8'h2D;  // '-'
  localparam logic [CHAR_BITS-1:0] CH_ZERO      = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] CH_NINE      = 8'h39;  // '9'
  localparam logic [CHAR_BITS-1:0] CH_LOWER_A   = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_F   = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_A   = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_F   = 8'h46;  // 'F'
  localparam logic [CHAR_BITS-1:0] CH_KOI_UP_A  = 8'hC1;
  localparam logic [CHAR_BITS-1:0] CH_KOI_UP_F  = 8'hC6;
  localparam logic [CHAR_BITS-1:0] CH_KOI_LO_A  = 8'hE1;
  localparam logic [CHAR_BITS-1:0] CH_KOI_LO_F  = 8'hE6;

  typedef struct packed {
    logic                       is_number;
    logic signed [OUT_BITS-1:0] number_value;
  } rtp_result_t;

  typedef struct packed {
    logic                  ok;
    logic [DIGIT_BITS-1:0] value;
  } rtp_digit_t;

endpackage

### src/radix_integer_token_parser_core.sv
`timescale 1ns / 1ps

// Parses one integer token per run of character beats (last character marked
// by in_tlast) in base 2, 8, 10 or 16 as set by the cfg register (reset:
// decimal). One character is accepted every cycle, back to back; the result
// of a token passes from the parse register into the output register behind
// out_tvalid. A result held by out_tready stalls the input only once the next
// token's last character reaches the parse register; other characters keep
// flowing. The per-cycle path is the accumulator update acc*base+digit, done
// with shifts and at most two adds.
// Invalid tokens give out_tuser = 0 and a zero value.
module radix_integer_token_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] number_value
  output logic        out_tuser,  // is_number
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // base_mode
);

  logic [rtp_pkg::MODE_BITS-1:0] base_r;
  logic                          out_v_r, out_v_nxt;
  rtp_pkg::rtp_result_t          out_res_r;
  rtp_pkg::rtp_result_t          res;
  logic                          res_valid;
  logic                          res_free;

  assign cfg_ready = 1'b1;
  assign res_free  = !out_v_r || out_tready;

  rtp_token u_token (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .base_mode (base_r),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    if (res_free) begin
      out_v_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= rtp_pkg::MODE_RESET;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.is_number;
  assign out_tdata  = out_res_r.number_value;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid token carries nonzero value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_res_r))
    else $error("pending result overwritten");

endmodule

### src/rtp_digit.sv
`timescale 1ns / 1ps

// Classifies one character as a digit of the selected base.
module rtp_digit (
  input  logic [rtp_pkg::CHAR_BITS-1:0] char_code,
  input  logic [rtp_pkg::MODE_BITS-1:0] base_mode,
  output rtp_pkg::rtp_digit_t           digit
);

  logic [rtp_pkg::CHAR_BITS-1:0]  c;
  logic [rtp_pkg::CHAR_BITS-1:0]  dec_off;
  logic [rtp_pkg::DIGIT_BITS-1:0] limit;
  logic                           is_dec;
  logic                           hex_mode;

  always_comb begin
    c       = char_code & rtp_pkg::CHAR_MASK;
    dec_off = c - rtp_pkg::CH_ZERO;
    unique case (base_mode)
      rtp_pkg::MODE_BIN: limit = 4'd1;
      rtp_pkg::MODE_OCT: limit = 4'd7;
      default:           limit = 4'd9;
    endcase
    is_dec   = (c >= rtp_pkg::CH_ZERO) && (c <= rtp_pkg::CH_NINE) &&
               (dec_off[rtp_pkg::DIGIT_BITS-1:0] <= limit);
    hex_mode = (base_mode == rtp_pkg::MODE_HEX);

    digit.ok    = 1'b0;
    digit.value = '0;
    priority if (is_dec) begin
      digit.ok    = 1'b1;
      digit.value = dec_off[rtp_pkg::DIGIT_BITS-1:0];
    end else if (hex_mode && c >= rtp_pkg::CH_LOWER_A && c <= rtp_pkg::CH_LOWER_F) begin
      digit.ok    = 1'b1;
      digit.value = 4'(c - rtp_pkg::CH_LOWER_A) + 4'd10;
    end else if (hex_mode && c >= rtp_pkg::CH_UPPER_A && c <= rtp_pkg::CH_UPPER_F) begin
      digit.ok    = 1'b1;
      digit.value = 4'(c - rtp_pkg::CH_UPPER_A) + 4'd10;
    end else if (hex_mode && c >= rtp_pkg::CH_KOI_UP_A && c <= rtp_pkg::CH_KOI_UP_F) begin
      digit.ok    = 1'b1;
      digit.value = 4'(c - rtp_pkg::CH_KOI_UP_A) + 4'd10;
    end else if (hex_mode && c >= rtp_pkg::CH_KOI_LO_A && c <= rtp_pkg::CH_KOI_LO_F) begin
      digit.ok    = 1'b1;
      digit.value = 4'(c - rtp_pkg::CH_KOI_LO_A) + 4'd10;
    end else begin
      digit.ok    = 1'b0;
    end
  end

endmodule

### src/rtp_token.sv
`timescale 1ns / 1ps

// Input register plus per-token state. One character is folded into the
// accumulator per beat; the last character produces a result.
module rtp_token (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rtp_pkg::CHAR_BITS-1:0] in_char,
  input  logic                          in_last,
  input  logic [rtp_pkg::MODE_BITS-1:0] base_mode,
  input  logic                          res_free,
  output logic                          res_valid,
  output rtp_pkg::rtp_result_t          res
);

  localparam int VB = rtp_pkg::VALUE_BITS;

  logic                          s1_v_r,    s1_v_nxt;
  logic [rtp_pkg::CHAR_BITS-1:0] s1_char_r;
  logic                          s1_last_r;

  logic [VB-1:0] acc_r,   acc_nxt;
  logic          neg_r,   neg_nxt;
  logic          bad_r,   bad_nxt;
  logic          start_r, start_nxt;
  logic          seen_r,  seen_nxt;

  rtp_pkg::rtp_digit_t digit;
  logic                fire;
  logic                take_sign;
  logic [VB-1:0]       scaled;
  logic [VB-1:0]       mag;

  rtp_digit u_digit (
    .char_code (s1_char_r),
    .base_mode (base_mode),
    .digit     (digit)
  );

  // A non-final character never needs the result register.
  assign fire     = s1_v_r && (!s1_last_r || res_free);
  assign in_ready = !s1_v_r || fire;

  always_comb begin
    unique case (base_mode)
      rtp_pkg::MODE_BIN: scaled = acc_r << 1;
      rtp_pkg::MODE_OCT: scaled = acc_r << 3;
      rtp_pkg::MODE_DEC: scaled = (acc_r << 3) + (acc_r << 1);
      rtp_pkg::MODE_HEX: scaled = acc_r << 4;
      default:           scaled = acc_r << 4;
    endcase
  end

  always_comb begin
    take_sign = start_r && (s1_char_r == rtp_pkg::CH_MINUS);
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    seen_nxt  = seen_r;
    start_nxt = start_r;
    s1_v_nxt  = in_ready ? in_valid : s1_v_r;

    if (fire) begin
      start_nxt = 1'b0;
      if (take_sign) begin
        neg_nxt = 1'b1;
      end else if (!bad_r) begin
        if (!digit.ok) begin
          bad_nxt = 1'b1;
        end else begin
          acc_nxt  = scaled + VB'(digit.value);
          seen_nxt = 1'b1;
        end
      end
      if (s1_last_r) begin
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        bad_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        start_nxt = 1'b1;
      end
    end
  end

  // Result from the post-update state of the final character.
  logic ok_final;
  logic [VB-1:0] acc_final;
  always_comb begin
    acc_final = acc_r;
    ok_final  = !bad_r && seen_r;
    if (take_sign) begin
      ok_final = ok_final && !bad_r;
    end else if (!bad_r) begin
      if (!digit.ok) begin
        ok_final = 1'b0;
      end else begin
        acc_final = scaled + VB'(digit.value);
        ok_final  = 1'b1;
      end
    end
    mag                = (neg_r || take_sign) ? (VB'(0) - acc_final) : acc_final;
    res_valid          = fire && s1_last_r;
    res.is_number      = ok_final;
    res.number_value   = ok_final ? rtp_pkg::OUT_BITS'($signed(mag)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      start_r <= 1'b1;
      seen_r  <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
      start_r <= start_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char;
      s1_last_r <= in_last;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_last_r |=> start_r && !bad_r && !seen_r && !neg_r && acc_r == '0)
    else $error("token state not cleared after last character");

  a_start_drops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_last_r |=> !start_r)
    else $error("token start flag held past first character");

  a_bad_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && bad_r && !s1_last_r |=> bad_r && $stable(acc_r))
    else $error("accumulator moved in a bad token");

endmodule
